### sv/aes128_block_encrypt_defines.svh
// Assertion macros for the AES-128 encryption block.
`ifndef AES128_BLOCK_ENCRYPT_DEFINES_SVH
`define AES128_BLOCK_ENCRYPT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define AES_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define AES_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/aes_pkg.sv
// Shared types, tables and round functions of the AES-128 encryption block.
package aes_pkg;

  localparam int unsigned NumRounds = 10;

  typedef logic [127:0] blk_t;

  typedef enum logic [0:0] {
    CFG_KEY_HIGH = 1'b0,
    CFG_KEY_LOW  = 1'b1
  } cfg_idx_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // byte n of a block sits in bits 127-8n .. 120-8n
  function automatic logic [7:0] get_byte(blk_t b, int unsigned n);
    return b[127 - 8*n -: 8];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes then ShiftRows
  function automatic blk_t sub_shift(blk_t s);
    blk_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(r + 4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
      end
    end
    return t;
  endfunction

  function automatic blk_t mix_columns(blk_t s);
    blk_t t;
    logic [7:0] a0, a1, a2, a3, al;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c + 1);
      a2 = get_byte(s, 4*c + 2);
      a3 = get_byte(s, 4*c + 3);
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 8*(4*c)     -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      t[127 - 8*(4*c + 1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      t[127 - 8*(4*c + 2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[127 - 8*(4*c + 3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // next round key from the previous one
  function automatic blk_t next_key(blk_t k, logic [7:0] rc);
    blk_t n;
    logic [31:0] t;
    t = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    n[127:96] = k[127:96] ^ t;
    n[95:64]  = k[95:64]  ^ n[127:96];
    n[63:32]  = k[63:32]  ^ n[95:64];
    n[31:0]   = k[31:0]   ^ n[63:32];
    return n;
  endfunction

endpackage

### sv/aes_round.sv
// One registered AES round with its key step; the last round skips MixColumns.
module aes_round #(
  parameter bit LastRound = 1'b0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_i,
  input  aes_pkg::blk_t  state_i,
  input  aes_pkg::blk_t  key_i,
  input  logic [7:0]     rcon_i,
  output logic           vld_o,
  output aes_pkg::blk_t  state_o,
  output aes_pkg::blk_t  key_o
);
  import aes_pkg::*;

  blk_t key_nxt, ss, state_nxt;
  logic vld_r;
  blk_t state_r, key_r;

  assign key_nxt = next_key(key_i, rcon_i);
  assign ss      = sub_shift(state_i);
  assign state_nxt = (LastRound ? ss : mix_columns(ss)) ^ key_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      state_r <= state_nxt;
      key_r   <= key_nxt;
    end
  end

  assign vld_o   = vld_r;
  assign state_o = state_r;
  assign key_o   = key_r;
endmodule

### sv/aes128_block_encrypt.sv
// AES-128 ECB encryption: fully unrolled 11-stage round pipeline.
// Stages: the initial AddRoundKey stage plus one registered stage per round,
//   ten rounds.
// Throughput: one block per cycle; the whole pipeline advances together and
//   freezes when the output beat is held, so a stall loses nothing.
// Reset: synchronous, active low; clears valid bits and both key registers.
module aes128_block_encrypt (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [127:0]  in_tdata,   // [63:0] plain_high, [127:64] plain_low
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [127:0]  out_tdata,  // [63:0] cipher_high, [127:64] cipher_low
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [0:0]    cfg_index,
  input  logic [63:0]   cfg_data
);
  import aes_pkg::*;

  logic [63:0] key_high_r, key_low_r;
  logic        en;
  logic        vld [NumRounds+1];
  blk_t        st  [NumRounds+1];
  blk_t        ky  [NumRounds+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_KEY_HIGH: key_high_r <= cfg_data;
        CFG_KEY_LOW:  key_low_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline moves whenever the output stage is empty or being drained
  assign en        = !vld[NumRounds] || out_tready;
  assign in_tready = en;

  // stage 0: initial AddRoundKey
  logic vld0_r;
  blk_t st0_r, ky0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      st0_r <= {in_tdata[63:0], in_tdata[127:64]} ^ {key_high_r, key_low_r};
      ky0_r <= {key_high_r, key_low_r};
    end
  end
  assign vld[0] = vld0_r;
  assign st[0]  = st0_r;
  assign ky[0]  = ky0_r;

  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    aes_round #(.LastRound(g == NumRounds - 1)) u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_i   (vld[g]),
      .state_i (st[g]),
      .key_i   (ky[g]),
      .rcon_i  (RCON[g]),
      .vld_o   (vld[g+1]),
      .state_o (st[g+1]),
      .key_o   (ky[g+1])
    );
  end

  assign out_tvalid = vld[NumRounds];
  assign out_tdata  = {st[NumRounds][63:0], st[NumRounds][127:64]};
endmodule

### sv/aes128_block_encrypt_chk.sv
// Port-level checker for the AES-128 encryption block, with its bind.
module aes128_block_encrypt_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata
);
`include "aes128_block_encrypt_defines.svh"

  logic stall;

  assign stall = out_tvalid && !out_tready;

  // a held output beat blocks new input
  `AES_ASSERT_IMP(a_stall_blocks_in, stall, !in_tready, "input taken during stall")
  // with the output free, input is always taken
  `AES_ASSERT_IMP(a_free_takes_in, !out_tvalid, in_tready, "input refused while output idle")
  // stalled result holds its data
  `AES_ASSERT_NXT(a_hold, stall, out_tvalid && $stable(out_tdata), "stalled result changed")
endmodule

bind aes128_block_encrypt aes128_block_encrypt_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
